// ===== rtl/dric_pkg.sv =====
// Package for the DMA register and IRQ controller: register offsets, bit positions,
// transfer kinds and the structs passed between the controller's modules.
// Depends on nothing; every other file of the block uses it.
package dric_pkg;

  localparam int NUM_CHANNELS_DEF  = 7;
  localparam int RAM_ADDR_BITS_DEF = 21;

  localparam int DATA_W  = 32;
  localparam int OFF_W   = 7;
  localparam int CHAN_W  = 3;
  localparam int XADDR_W = 24;
  localparam int WORDS_W = 33;
  localparam int LEN_W   = 17;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 104;

  typedef enum logic {
    CMD_READ,
    CMD_WRITE
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_TO_DEV,
    KIND_FROM_DEV,
    KIND_LIST,
    KIND_OTC
  } kind_t;

  localparam logic [OFF_W-1:0] OFF_ENABLE = 7'h70;
  localparam logic [OFF_W-1:0] OFF_IRQ    = 7'h74;

  localparam logic [1:0] SUB_ADDR = 2'd0;
  localparam logic [1:0] SUB_BCR  = 2'd1;
  localparam logic [1:0] SUB_CTRL = 2'd2;
  localparam logic [1:0] SUB_NONE = 2'd3;

  localparam logic [CHAN_W-1:0] CH_MDEC_IN = 3'd0;
  localparam logic [CHAN_W-1:0] CH_SPU     = 3'd4;
  localparam logic [CHAN_W-1:0] CH_GPU     = 3'd2;
  localparam logic [CHAN_W-1:0] CH_PIO     = 3'd5;
  localparam logic [CHAN_W-1:0] CH_OTC     = 3'd6;
  localparam logic [CHAN_W-1:0] CH_NONE    = 3'd7;

  localparam logic [1:0] SYNC_MANUAL = 2'd0;
  localparam logic [1:0] SYNC_BLOCK  = 2'd1;
  localparam logic [1:0] SYNC_LIST   = 2'd2;

  localparam int CTRL_START_BIT   = 24;
  localparam int CTRL_TRIGGER_BIT = 28;

  localparam logic [DATA_W-1:0]  OTC_CTRL_VALUE = 32'h1100_0002;
  localparam logic [XADDR_W-1:0] LIST_END_ADDR  = 24'hFF_FFFF;
  localparam logic [LEN_W-1:0]   LEN_FULL       = 17'h1_0000;
  localparam logic [LEN_W-1:0]   LEN_ONE        = 17'h0_0001;

  localparam logic [DATA_W-1:0] IRQ_WR_MASK    = 32'h00FF_803F;
  localparam int                IRQ_FORCE_BIT  = 15;
  localparam int                IRQ_MASTER_EN  = 23;
  localparam int                IRQ_MASTER_BIT = 31;

  typedef struct packed {
    cmd_t              cmd;
    logic [OFF_W-1:0]  reg_offset;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic               start;
    logic [CHAN_W-1:0]  channel;
    logic [XADDR_W-1:0] address;
    logic [WORDS_W-1:0] words;
    logic               backward;
    kind_t              kind;
  } xfer_t;

  typedef struct packed {
    logic               ctrl_we;
    logic [DATA_W-1:0]  ctrl_val;
    logic               raise;
    logic               addr_we;
    logic [XADDR_W-1:0] addr_val;
  } chan_upd_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_rise;
    xfer_t             xfer;
  } resp_t;

endpackage

// ===== rtl/dric_ctrl_calc.sv =====
// Channel-control write decision for the DMA controller: start rules, word count,
// descriptor and end address for one control-register write.
// Depends on dric_pkg.
module dric_ctrl_calc #(
  parameter int RAM_ADDR_BITS = dric_pkg::RAM_ADDR_BITS_DEF
) (
  input  logic [dric_pkg::CHAN_W-1:0] ch,
  input  logic [dric_pkg::DATA_W-1:0] data,
  input  logic [dric_pkg::DATA_W-1:0] bcr,
  input  logic [dric_pkg::DATA_W-1:0] addr,
  input  logic [dric_pkg::DATA_W-1:0] old_ctrl,
  input  logic                        enabled,
  output dric_pkg::chan_upd_t         upd,
  output dric_pkg::xfer_t             xfer
);

  localparam logic [dric_pkg::XADDR_W-1:0] RAM_MASK =
    dric_pkg::XADDR_W'((25'd1 << RAM_ADDR_BITS) - 25'd1) & ~24'd3;

  logic [1:0]                     sync;
  logic                           start_cond;
  logic [dric_pkg::LEN_W-1:0]     len;
  logic [dric_pkg::LEN_W-1:0]     factor;
  logic [2*dric_pkg::LEN_W-1:0]   prod;
  logic [dric_pkg::WORDS_W-1:0]   words;
  logic [dric_pkg::XADDR_W-1:0]   start_addr;
  logic [dric_pkg::XADDR_W-1:0]   span;
  logic [dric_pkg::XADDR_W-1:0]   end_addr;
  logic                           go;
  logic                           back;
  logic                           guarded;
  logic [dric_pkg::DATA_W-1:0]    data_clr;
  dric_pkg::kind_t                kind;

  assign sync       = data[10:9];
  assign start_cond = enabled && data[dric_pkg::CTRL_START_BIT] &&
                      ((sync != dric_pkg::SYNC_MANUAL) || data[dric_pkg::CTRL_TRIGGER_BIT]);
  assign len        = (bcr[15:0] == 16'd0) ? dric_pkg::LEN_FULL : {1'b0, bcr[15:0]};
  assign data_clr   = data & ~(32'd1 << dric_pkg::CTRL_START_BIT);
  assign guarded    = ((ch == dric_pkg::CH_GPU) || (ch == dric_pkg::CH_PIO) ||
                       (ch == dric_pkg::CH_OTC)) && old_ctrl[dric_pkg::CTRL_START_BIT];

  always_comb begin
    factor = dric_pkg::LEN_ONE;
    if (ch == dric_pkg::CH_GPU) begin
      if (sync != dric_pkg::SYNC_MANUAL) begin
        factor = (bcr[31:16] == 16'd0) ? dric_pkg::LEN_ONE : {1'b0, bcr[31:16]};
      end
    end else if (ch != dric_pkg::CH_OTC) begin
      if (sync == dric_pkg::SYNC_BLOCK) begin
        factor = (bcr[31:16] == 16'd0) ? dric_pkg::LEN_FULL : {1'b0, bcr[31:16]};
      end
    end
  end

  assign prod  = len * factor;
  assign words = prod[dric_pkg::WORDS_W-1:0];

  always_comb begin
    upd.ctrl_we = !guarded;
    upd.ctrl_val = data;
    upd.raise = 1'b0;
    go = 1'b0;
    back = data[1];
    kind = dric_pkg::KIND_FROM_DEV;
    case (ch)
      dric_pkg::CH_PIO: begin
        upd.ctrl_val = data_clr;
        upd.raise = !guarded;
      end
      dric_pkg::CH_OTC: begin
        upd.ctrl_val = data_clr;
        go = !guarded && data[dric_pkg::CTRL_START_BIT] && enabled &&
             (data == dric_pkg::OTC_CTRL_VALUE);
        back = 1'b1;
        kind = dric_pkg::KIND_OTC;
      end
      dric_pkg::CH_GPU: begin
        upd.ctrl_val = data_clr;
        upd.raise = !guarded;
        go = !guarded && start_cond;
        if (sync == dric_pkg::SYNC_LIST) begin
          kind = dric_pkg::KIND_LIST;
          back = 1'b0;
        end else begin
          kind = data[0] ? dric_pkg::KIND_TO_DEV : dric_pkg::KIND_FROM_DEV;
        end
      end
      dric_pkg::CH_MDEC_IN: begin
        go = start_cond;
        kind = dric_pkg::KIND_TO_DEV;
      end
      dric_pkg::CH_SPU: begin
        go = start_cond;
        kind = data[0] ? dric_pkg::KIND_TO_DEV : dric_pkg::KIND_FROM_DEV;
      end
      default: begin
        go = start_cond;
      end
    endcase
    if (go && (ch != dric_pkg::CH_GPU) && (ch != dric_pkg::CH_OTC)) begin
      upd.ctrl_val = data_clr;
      upd.raise = 1'b1;
    end
  end

  assign start_addr = addr[dric_pkg::XADDR_W-1:0] & RAM_MASK;
  assign span       = {words[dric_pkg::XADDR_W-3:0], 2'b00};
  assign end_addr   = (back ? (start_addr - span) : (start_addr + span)) & RAM_MASK;

  always_comb begin
    upd.addr_we = go;
    upd.addr_val = (kind == dric_pkg::KIND_LIST) ? dric_pkg::LIST_END_ADDR : end_addr;
    xfer.start = go;
    xfer.channel = go ? ch : '0;
    xfer.address = go ? start_addr : '0;
    xfer.words = (go && (kind != dric_pkg::KIND_LIST)) ? words : '0;
    xfer.backward = go && back;
    xfer.kind = go ? kind : dric_pkg::KIND_TO_DEV;
  end

endmodule

// ===== rtl/dric_regs.sv =====
// Register file of the DMA controller: channel, enable and interrupt registers,
// request decode, read mux and master interrupt flag.
// Depends on dric_pkg and dric_ctrl_calc.
module dric_regs #(
  parameter int NUM_CHANNELS  = dric_pkg::NUM_CHANNELS_DEF,
  parameter int RAM_ADDR_BITS = dric_pkg::RAM_ADDR_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  dric_pkg::req_t  req,
  output dric_pkg::resp_t resp
);

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [dric_pkg::DATA_W-1:0] addr_r [NUM_CHANNELS];
  logic [dric_pkg::DATA_W-1:0] bcr_r  [NUM_CHANNELS];
  logic [dric_pkg::DATA_W-1:0] ctrl_r [NUM_CHANNELS];
  logic [dric_pkg::DATA_W-1:0] enable_r;
  logic [dric_pkg::DATA_W-1:0] irq_r;
  logic [dric_pkg::DATA_W-1:0] irq_nxt;
  logic                        master_prev_r;
  logic                        master_prev_nxt;

  logic [dric_pkg::CHAN_W-1:0] chi;
  logic [CH_IDX_W-1:0]         cidx;
  logic [1:0]                  sub;
  logic                        is_wr;
  logic                        aligned;
  logic                        hit_en;
  logic                        hit_irq;
  logic                        hit_chan;
  logic                        wr_addr;
  logic                        wr_bcr;
  logic                        wr_ctrl;
  logic [dric_pkg::DATA_W-1:0] sel_addr;
  logic [dric_pkg::DATA_W-1:0] sel_bcr;
  logic [dric_pkg::DATA_W-1:0] sel_ctrl;
  logic                        chan_en;
  dric_pkg::chan_upd_t         upd;
  dric_pkg::xfer_t             xfer;
  logic [dric_pkg::DATA_W-1:0] irq_w;
  logic [6:0]                  flag_set;
  logic                        irq_update;
  logic                        flag;
  logic [dric_pkg::DATA_W-1:0] wd;

  assign wd      = req.write_data;
  assign is_wr   = (req.cmd == dric_pkg::CMD_WRITE);
  assign aligned = (req.reg_offset[1:0] == 2'b00);
  assign hit_en  = (req.reg_offset == dric_pkg::OFF_ENABLE);
  assign hit_irq = (req.reg_offset == dric_pkg::OFF_IRQ);
  assign chi     = req.reg_offset[6:4];
  assign sub     = req.reg_offset[3:2];
  assign cidx    = chi[CH_IDX_W-1:0];
  assign hit_chan = aligned && (chi != dric_pkg::CH_NONE) &&
                    (32'(chi) < NUM_CHANNELS) && (sub != dric_pkg::SUB_NONE);

  assign wr_addr = hit_chan && is_wr && (sub == dric_pkg::SUB_ADDR);
  assign wr_bcr  = hit_chan && is_wr && (sub == dric_pkg::SUB_BCR);
  assign wr_ctrl = hit_chan && is_wr && (sub == dric_pkg::SUB_CTRL);

  assign sel_addr = addr_r[cidx];
  assign sel_bcr  = bcr_r[cidx];
  assign sel_ctrl = ctrl_r[cidx];
  assign chan_en  = enable_r[{chi, 2'b11}];

  dric_ctrl_calc #(
    .RAM_ADDR_BITS(RAM_ADDR_BITS)
  ) u_ctrl_calc (
    .ch      (chi),
    .data    (wd),
    .bcr     (sel_bcr),
    .addr    (sel_addr),
    .old_ctrl(sel_ctrl),
    .enabled (chan_en),
    .upd     (upd),
    .xfer    (xfer)
  );

  always_comb begin
    flag_set = irq_r[{2'b10, chi}] ? (7'd1 << chi) : 7'd0;
    irq_w = irq_r;
    irq_update = 1'b0;
    if (hit_irq && is_wr) begin
      irq_w = (irq_r & ~dric_pkg::IRQ_WR_MASK) | (wd & dric_pkg::IRQ_WR_MASK);
      irq_w = irq_w & ~{1'b0, wd[30:24], 24'd0};
      irq_w[dric_pkg::IRQ_FORCE_BIT] = irq_w[dric_pkg::IRQ_FORCE_BIT] &
                                       !wd[dric_pkg::IRQ_FORCE_BIT];
      irq_update = 1'b1;
    end else if (wr_ctrl && upd.raise) begin
      irq_w = irq_r | {1'b0, flag_set, 24'd0};
      irq_update = 1'b1;
    end
    flag = irq_w[dric_pkg::IRQ_FORCE_BIT] ||
           (irq_w[dric_pkg::IRQ_MASTER_EN] && ((irq_w[22:16] & irq_w[30:24]) != 7'd0));
    irq_nxt = irq_r;
    master_prev_nxt = master_prev_r;
    if (irq_update) begin
      irq_nxt = {flag, irq_w[30:0]};
      master_prev_nxt = flag;
    end
  end

  always_comb begin
    resp.read_data = '0;
    if (aligned && !is_wr) begin
      if (hit_en) begin
        resp.read_data = enable_r;
      end else if (hit_irq) begin
        resp.read_data = irq_r;
      end else if (hit_chan) begin
        case (sub)
          dric_pkg::SUB_ADDR: resp.read_data = sel_addr;
          dric_pkg::SUB_BCR:  resp.read_data = sel_bcr;
          default:            resp.read_data = sel_ctrl;
        endcase
      end
    end
    resp.irq_rise = irq_update && flag && !master_prev_r;
    resp.xfer = wr_ctrl ? xfer : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        addr_r[i] <= '0;
        bcr_r[i] <= '0;
        ctrl_r[i] <= '0;
      end
      enable_r <= '0;
      irq_r <= '0;
      master_prev_r <= 1'b0;
    end else if (step) begin
      if (wr_addr) begin
        addr_r[cidx] <= wd;
      end else if (wr_ctrl && upd.addr_we) begin
        addr_r[cidx] <= {8'd0, upd.addr_val};
      end
      if (wr_bcr) begin
        bcr_r[cidx] <= wd;
      end
      if (wr_ctrl && upd.ctrl_we) begin
        ctrl_r[cidx] <= upd.ctrl_val;
      end
      if (hit_en && is_wr) begin
        enable_r <= wd;
      end
      irq_r <= irq_nxt;
      master_prev_r <= master_prev_nxt;
    end
  end

  a_master_tracks_prev: assert property (@(posedge clk) disable iff (!rst_n)
    irq_r[dric_pkg::IRQ_MASTER_BIT] == master_prev_r)
    else $error("stored master flag differs from its previous-value register");

  a_irq_force_clear: assert property (@(posedge clk) disable iff (!rst_n)
    irq_r[15:6] == 10'd0)
    else $error("interrupt register holds bits that a write must leave clear");

endmodule

// ===== rtl/dma_register_and_irq_controller_top.sv =====
// Top level of the DMA register and IRQ controller: request and response stream
// stages around the register file.
// Depends on dric_pkg and dric_regs.
//
// Each request (read or write of one DMA register) is taken from the in_ stream
// and answered with exactly one response on the out_ stream; the block takes one
// request per clock unless out_tready holds a response. A request is held in the
// request register, and its response is registered in the response register that
// drives out_. While out_tready is low the response is held; once the request
// register also holds a request, in_tready falls until the response is taken.
// A write to a channel-control register that starts a transfer reports it in the
// response as a descriptor (channel, start address, word count, direction, kind);
// no data is moved. irq_rise marks the response whose request raised the master
// interrupt flag.
module dma_register_and_irq_controller_top #(
  parameter int NUM_CHANNELS  = dric_pkg::NUM_CHANNELS_DEF,
  parameter int RAM_ADDR_BITS = dric_pkg::RAM_ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // cmd[0], reg_offset[7:1], write_data[39:8]
  input  logic [dric_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // read_data[31:0], irq_rise[32], xfer_start[33], xfer_channel[36:34],
  // xfer_address[60:37], xfer_words[93:61], xfer_backward[94], xfer_kind[96:95],
  // zero padding[103:97]
  output logic [dric_pkg::OUT_W-1:0] out_tdata
);

  logic            s1_valid_r;
  logic            s1_valid_nxt;
  dric_pkg::req_t  s1_req_r;
  logic            out_valid_r;
  logic            out_valid_nxt;
  dric_pkg::resp_t out_resp_r;
  dric_pkg::resp_t resp;
  logic            adv;
  logic            fire;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign fire      = s1_valid_r && adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_req_r.cmd <= dric_pkg::cmd_t'(in_tdata[0]);
      s1_req_r.reg_offset <= in_tdata[7:1];
      s1_req_r.write_data <= in_tdata[39:8];
    end
    if (fire) begin
      out_resp_r <= resp;
    end
  end

  dric_regs #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .RAM_ADDR_BITS(RAM_ADDR_BITS)
  ) u_regs (
    .clk  (clk),
    .rst_n(rst_n),
    .step (fire),
    .req  (s1_req_r),
    .resp (resp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0,
                       out_resp_r.xfer.kind,
                       out_resp_r.xfer.backward,
                       out_resp_r.xfer.words,
                       out_resp_r.xfer.address,
                       out_resp_r.xfer.channel,
                       out_resp_r.xfer.start,
                       out_resp_r.irq_rise,
                       out_resp_r.read_data};

  a_fire_gives_response: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("a processed request produced no response");

  a_xfer_write_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_resp_r.xfer.start) |-> (out_resp_r.read_data == '0))
    else $error("a transfer start was reported with nonzero read data");

  a_idle_descriptor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_resp_r.xfer.start) |->
      ((out_resp_r.xfer.words == '0) && (out_resp_r.xfer.address == '0) &&
       (out_resp_r.xfer.channel == '0) && !out_resp_r.xfer.backward))
    else $error("descriptor fields set without a transfer start");

endmodule
